// ===== sv/crr_pkg.sv =====
// Shared types and codes for the chunked report reassembler.
// No dependencies; used by crr_core, crr_copy and the top level.
package crr_pkg;

  localparam int BYTE_W     = 8;
  localparam int STAGE_AW   = 9;   // two 256-byte payload banks
  localparam int POS_W      = 9;
  localparam int CHUNK_W    = 7;
  localparam int LEN_OUT_W  = 12;
  localparam int STATUS_W   = 3;
  localparam int REQ_W      = 2;
  localparam int INDEX_W    = 11;

  localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TAKE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FIRST   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_APPEND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROP    = 3'd4;

  localparam logic [CHUNK_W-1:0] CHUNK_MASK = 7'h7F;
  localparam int                 FINAL_BIT  = 7;   // header bit 0x80

  // Packed so that it maps straight onto the output tdata, status lowest.
  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic [LEN_OUT_W-1:0] length;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
  } result_t;

  typedef struct packed {
    logic                start;
    logic                bank;
    logic [BYTE_W-1:0]   len;
  } copy_req_t;

  typedef struct packed {
    logic                we;
    logic [STAGE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } stage_wr_t;

endpackage

// ===== sv/crr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module crr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/crr_copy.sv =====
// Copy engine: moves an accepted payload from a staging bank into the message store.
// Depends on crr_pkg.
module crr_copy #(
  parameter int AW = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crr_pkg::copy_req_t          req_i,
  input  logic [AW-1:0]               dest_i,
  input  logic [crr_pkg::BYTE_W-1:0]  stage_rdata_i,
  output logic                        busy_o,
  output logic                        stage_re_o,
  output logic [crr_pkg::STAGE_AW-1:0] stage_raddr_o,
  output logic                        store_we_o,
  output logic [AW-1:0]               store_waddr_o,
  output logic [crr_pkg::BYTE_W-1:0]  store_wdata_o
);

  logic                       busy_q;
  logic                       pend_q;
  logic                       bank_q;
  logic [crr_pkg::BYTE_W-1:0] len_q;
  logic [crr_pkg::BYTE_W-1:0] ci_q;
  logic [AW-1:0]              dst_q;
  logic [AW-1:0]              waddr_q;
  logic                       issue;

  assign issue = busy_q && (ci_q != len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && !issue && pend_q) begin
        // last byte lands in the store at this edge
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      bank_q <= req_i.bank;
      len_q  <= req_i.len;
      ci_q   <= '0;
      dst_q  <= dest_i;
    end else if (issue) begin
      ci_q <= ci_q + 8'd1;
    end
    if (issue) begin
      waddr_q <= dst_q + AW'(ci_q);
    end
  end

  assign busy_o        = busy_q;
  assign stage_re_o    = issue;
  assign stage_raddr_o = {bank_q, ci_q};
  assign store_we_o    = pend_q;
  assign store_waddr_o = waddr_q;
  assign store_wdata_o = stage_rdata_i;

endmodule

// ===== sv/crr_core.sv =====
// Reassembly state and per-request logic: header capture, report judging, take and read.
// Depends on crr_pkg.
module crr_core #(
  parameter int MAX_MESSAGE = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic [crr_pkg::REQ_W-1:0]    req_i,
  input  logic [crr_pkg::BYTE_W-1:0]   byte_i,
  input  logic                         last_i,
  input  logic [crr_pkg::BYTE_W-1:0]   rdata_i,
  output crr_pkg::result_t             res_o,
  output crr_pkg::stage_wr_t           stw_o,
  output crr_pkg::copy_req_t           cpy_o,
  output logic [$clog2(MAX_MESSAGE)-1:0] dest_o
);

  localparam int AW  = $clog2(MAX_MESSAGE);
  localparam int CLW = $clog2(MAX_MESSAGE + 1);
  localparam int POS_W = crr_pkg::POS_W;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_PARTIAL  = 2'd1;
  localparam logic [1:0] PH_COMPLETE = 2'd2;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic [1:0]                   phase_q, phase_d;
  logic [crr_pkg::CHUNK_W-1:0]  exp_q, exp_d;
  logic [CLW-1:0]               comm_q, comm_d;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [crr_pkg::CHUNK_W-1:0]  hc_q, hc_d;
  logic                         hf_q, hf_d;
  logic [crr_pkg::BYTE_W-1:0]   pl_q, pl_d;
  logic                         wb_q, wb_d;

  logic [crr_pkg::BYTE_W-1:0]   pl_eff;
  logic [POS_W-1:0]             pos_m1;
  logic [POS_W-1:0]             pos_m2;
  logic                         short_pay;
  logic                         overflow;
  logic [crr_pkg::CHUNK_W:0]    exp_inc;
  logic                         append_ok;
  logic                         accepted;
  logic [crr_pkg::STATUS_W-1:0] status;
  logic [crr_pkg::LEN_OUT_W-1:0] length;
  logic [crr_pkg::BYTE_W-1:0]   data;

  assign pl_eff    = (pos_q == POS_W'(1)) ? byte_i : pl_q;
  assign pos_m1    = pos_q - POS_W'(1);
  assign pos_m2    = pos_q - POS_W'(2);
  assign short_pay = {1'b0, pl_eff} > pos_m1;
  assign overflow  = ((CLW+1)'(pl_eff) + (CLW+1)'(comm_q)) > (CLW+1)'(MAX_MESSAGE);
  assign exp_inc   = {1'b0, exp_q} + 8'd1;
  assign append_ok = (phase_q == PH_PARTIAL) && ({1'b0, hc_q} == exp_inc);

  always_comb begin
    phase_d  = phase_q;
    exp_d    = exp_q;
    comm_d   = comm_q;
    pos_d    = pos_q;
    hc_d     = hc_q;
    hf_d     = hf_q;
    pl_d     = pl_q;
    wb_d     = wb_q;
    status   = crr_pkg::ST_BUSY;
    length   = '0;
    data     = '0;
    accepted = 1'b0;
    stw_o.we   = 1'b0;
    stw_o.addr = {wb_q, pos_m2[7:0]};
    stw_o.data = byte_i;

    if (adv_i) begin
      case (req_i)
        crr_pkg::REQ_REPORT: begin
          if (pos_q == '0) begin
            hc_d = byte_i[crr_pkg::CHUNK_W-1:0] & crr_pkg::CHUNK_MASK;
            hf_d = byte_i[crr_pkg::FINAL_BIT];
          end else if (pos_q == POS_W'(1)) begin
            pl_d = byte_i;
          end else if (pos_m2 < {1'b0, pl_q}) begin
            stw_o.we = 1'b1;
          end

          if (last_i) begin
            pos_d = '0;
            if (pos_q == '0 || short_pay || overflow) begin
              phase_d = PH_IDLE;
              exp_d   = '0;
              comm_d  = '0;
              status  = crr_pkg::ST_DROP;
            end else if (hc_q == '0) begin
              phase_d  = hf_q ? PH_COMPLETE : PH_PARTIAL;
              exp_d    = '0;
              comm_d   = CLW'(pl_eff);
              status   = crr_pkg::ST_FIRST;
              accepted = 1'b1;
            end else if (append_ok) begin
              phase_d  = hf_q ? PH_COMPLETE : PH_PARTIAL;
              exp_d    = exp_inc[crr_pkg::CHUNK_W-1:0] & crr_pkg::CHUNK_MASK;
              comm_d   = comm_q + CLW'(pl_eff);
              status   = crr_pkg::ST_APPEND;
              accepted = 1'b1;
            end else if (hc_q == exp_q) begin
              // duplicate: store untouched, but its final flag still counts
              if (phase_q == PH_PARTIAL && hf_q) begin
                phase_d = PH_COMPLETE;
              end
              status = crr_pkg::ST_DUP;
            end else begin
              phase_d = PH_IDLE;
              exp_d   = '0;
              comm_d  = '0;
              status  = crr_pkg::ST_DROP;
            end
          end else if (pos_q != POS_MAX) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        crr_pkg::REQ_TAKE: begin
          if (phase_q == PH_COMPLETE) begin
            length  = crr_pkg::LEN_OUT_W'(comm_q);
            phase_d = PH_IDLE;
            exp_d   = '0;
            comm_d  = '0;
          end
        end
        crr_pkg::REQ_READ: begin
          data = rdata_i;
        end
        default: begin
        end
      endcase
    end

    cpy_o.start = accepted && (pl_eff != '0);
    cpy_o.bank  = wb_q;
    cpy_o.len   = pl_eff;
    if (cpy_o.start) begin
      // hand the filled bank to the copier, stage the next report in the other
      wb_d = ~wb_q;
    end
  end

  assign dest_o = (hc_q == '0) ? '0 : AW'(comm_q);

  assign res_o.status = status;
  assign res_o.ready  = (phase_d == PH_COMPLETE);
  assign res_o.length = length;
  assign res_o.data   = data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      exp_q   <= '0;
      comm_q  <= '0;
      pos_q   <= '0;
      hc_q    <= '0;
      hf_q    <= 1'b0;
      pl_q    <= '0;
      wb_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      exp_q   <= exp_d;
      comm_q  <= comm_d;
      pos_q   <= pos_d;
      hc_q    <= hc_d;
      hf_q    <= hf_d;
      pl_q    <= pl_d;
      wb_q    <= wb_d;
    end
  end

endmodule

// ===== sv/chunked_report_reassembler_unit.sv =====
// Chunked report reassembler: top level with request and result registers.
// Depends on crr_pkg, crr_ram, crr_core and crr_copy.
//
// Requests enter on the s_axis channel, one per cycle: a report byte
// (tuser 0, tlast on the final byte of a report), a take of the finished
// message length (tuser 1) or a read of a stored byte (tuser 2).
// Every request yields exactly one result on m_axis.
// A request passes through the request register, then the result register.
// Throughput is one request per cycle while no request is held off and m_axis
// is not stalled. An accepted report payload is moved from a staging bank into
// the message store by a copy engine at one byte per cycle; while it runs,
// read requests and the final byte of the next report are held off.
// Other report bytes and takes keep flowing.
// A stalled receiver holds the result register; one more request is taken
// into the request register and then tready drops.
// Reset clears all control state; message store contents are undefined
// until written. MAX_MESSAGE must be a power of two; read indexes wrap.
module chunked_report_reassembler_unit #(
  parameter int MAX_MESSAGE = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] report_byte, [18:8] read_index
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  input  logic        s_axis_tlast,   // report_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] report_status, [3] message_ready,
                                      // [15:4] message_length, [23:16] read_data
);

  localparam int AW = $clog2(MAX_MESSAGE);

  logic                        a_valid_q;
  logic [crr_pkg::REQ_W-1:0]   a_req_q;
  logic [crr_pkg::BYTE_W-1:0]  a_byte_q;
  logic                        a_last_q;
  logic                        out_valid_q;
  crr_pkg::result_t            out_q;

  logic                        a_adv;
  logic                        in_acc;
  logic                        in_block;
  logic                        copy_busy;

  crr_pkg::result_t            res;
  crr_pkg::stage_wr_t          stw;
  crr_pkg::copy_req_t          cpy;
  logic [AW-1:0]               dest;

  logic [crr_pkg::BYTE_W-1:0]  store_rdata;
  logic                        store_we;
  logic [AW-1:0]               store_waddr;
  logic [crr_pkg::BYTE_W-1:0]  store_wdata;
  logic                        stage_re;
  logic [crr_pkg::STAGE_AW-1:0] stage_raddr;
  logic [crr_pkg::BYTE_W-1:0]  stage_rdata;

  assign a_adv = a_valid_q && (!out_valid_q || m_axis_tready);

  // hold off requests that would race the copy into the store
  assign in_block = (copy_busy || cpy.start) &&
                    ((s_axis_tuser == crr_pkg::REQ_READ) ||
                     ((s_axis_tuser == crr_pkg::REQ_REPORT) && s_axis_tlast));

  assign s_axis_tready = (!a_valid_q || a_adv) && !in_block;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_req_q  <= s_axis_tuser;
      a_byte_q <= s_axis_tdata[7:0];
      a_last_q <= s_axis_tlast;
    end
    if (a_adv) begin
      out_q <= res;
    end
  end

  crr_core #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (a_adv),
    .req_i   (a_req_q),
    .byte_i  (a_byte_q),
    .last_i  (a_last_q),
    .rdata_i (store_rdata),
    .res_o   (res),
    .stw_o   (stw),
    .cpy_o   (cpy),
    .dest_o  (dest)
  );

  crr_copy #(
    .AW (AW)
  ) u_copy (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (cpy),
    .dest_i        (dest),
    .stage_rdata_i (stage_rdata),
    .busy_o        (copy_busy),
    .stage_re_o    (stage_re),
    .stage_raddr_o (stage_raddr),
    .store_we_o    (store_we),
    .store_waddr_o (store_waddr),
    .store_wdata_o (store_wdata)
  );

  crr_ram #(
    .WIDTH (crr_pkg::BYTE_W),
    .DEPTH (1 << crr_pkg::STAGE_AW)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stw.we),
    .waddr_i (stw.addr),
    .wdata_i (stw.data),
    .re_i    (stage_re),
    .raddr_i (stage_raddr),
    .rdata_o (stage_rdata)
  );

  crr_ram #(
    .WIDTH (crr_pkg::BYTE_W),
    .DEPTH (MAX_MESSAGE)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (store_wdata),
    .re_i    (in_acc && (s_axis_tuser == crr_pkg::REQ_READ)),
    .raddr_i (AW'(s_axis_tdata[18:8])),
    .rdata_o (store_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
